[src/hvcc_to_annexb_converter_macros.svh]
// ----------------------------------------------------------------------------
// hvcc to annex b converter assertion macros
// concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef HVCC_TO_ANNEXB_CONVERTER_MACROS_SVH
`define HVCC_TO_ANNEXB_CONVERTER_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define HVCC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// consequent must hold in the cycle after the antecedent
`define HVCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define HVCC_ASSERT(lbl, clk, rst_n, prop, msg)
`define HVCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

[src/hvcc_pkg.sv]
// ----------------------------------------------------------------------------
// hvcc_pkg
// shared types and constants of the hvcc to annex b converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hvcc_pkg;

	localparam int COUNT_BITS_DEF = 20;
	localparam int CAP_BITS       = 20;
	localparam logic [CAP_BITS-1:0] CAP_RESET = 20'hFFFFF;

	// record layout
	localparam int HDR_LEN      = 23;
	localparam int HDR_LSZ_POS  = 21;
	localparam int HDR_CNT_POS  = HDR_LEN - 1;
	localparam int SHORT_MAX    = 3;
	localparam logic [1:0] LSZ_MASK = 2'h3;
	localparam int START_LEN    = 4;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NOT_LP    = 3'd1;
	localparam logic [2:0] ST_HDR_SHORT = 3'd2;
	localparam logic [2:0] ST_ARR_TRUNC = 3'd3;
	localparam logic [2:0] ST_LEN_TRUNC = 3'd4;
	localparam logic [2:0] ST_NAL_TRUNC = 3'd5;
	localparam logic [2:0] ST_OVERFLOW  = 3'd6;

	// command queue between parser and emitter
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic                emit_start;
		logic                emit_data;
		logic [7:0]          data;
		logic                emit_status;
		logic [2:0]          code;
		logic [CAP_BITS-1:0] total;
		logic [2:0]          lsz;
	} cmd_t;

	typedef struct packed {
		logic push;
		logic full;
	} q_ctl_t;

endpackage

[src/hvcc_to_annexb_converter.sv]
// ----------------------------------------------------------------------------
// hvcc_to_annexb_converter
// converts an hvcc configuration record into an annex b byte stream
// ----------------------------------------------------------------------------
// input channel: one record byte per transfer on in_valid/in_ready, in_last
// on the final byte. output channel: out_valid/out_ready items, each either
// an annex b byte (is_status 0) or the closing status item (is_status 1,
// last 1) with the error code, byte count and length-field size.
// one input byte is taken per cycle while the queue is not full; a nal length
// that completes expands to four start code bytes, which the emitter sends
// while the parser runs ahead into a four-entry command queue. payload bytes
// flow at one per cycle while the receiver keeps up. with the queue empty, an
// item is written into a queue entry when its byte is transferred and then
// into the output register. when the receiver stalls, the output register
// holds and the queue fills; in_ready drops only when the queue is full.
// out_capacity is written over the apb port at any address with paddr[2] low.
// reset empties the queue, clears the parser and sets out_capacity to its
// largest value; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hvcc_to_annexb_converter #(
	parameter int COUNT_BITS = hvcc_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    in_byte,
	input  logic                          in_last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    out_byte,
	output logic                          is_status,
	output logic [2:0]                    status,
	output logic [hvcc_pkg::CAP_BITS-1:0] total_bytes,
	output logic [2:0]                    length_field_size,
	output logic                          last
);
	import hvcc_pkg::*;

	logic [CAP_BITS-1:0] cap_q;
	q_ctl_t              q_ctl;
	cmd_t                wr_cmd, head;
	logic                q_full, q_empty, pop;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {{(32-CAP_BITS){1'b0}}, cap_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			cap_q <= pwdata[CAP_BITS-1:0];
		end
	end

	hvcc_parse #(
		.COUNT_BITS(COUNT_BITS)
	) u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_byte      (in_byte),
		.in_last      (in_last),
		.out_capacity (cap_q),
		.q_ctl        (q_ctl),
		.q_full       (q_full),
		.cmd          (wr_cmd)
	);

	hvcc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_ctl  (q_ctl),
		.wr_cmd (wr_cmd),
		.pop    (pop),
		.full   (q_full),
		.empty  (q_empty),
		.head   (head)
	);

	hvcc_emit u_emit (
		.clk               (clk),
		.arst_n            (arst_n),
		.empty             (q_empty),
		.head              (head),
		.pop               (pop),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.out_byte          (out_byte),
		.is_status         (is_status),
		.status            (status),
		.total_bytes       (total_bytes),
		.length_field_size (length_field_size),
		.last              (last)
	);

endmodule

[src/hvcc_parse.sv]
// ----------------------------------------------------------------------------
// hvcc_parse
// walks the hvcc record one byte per transfer and queues emit commands
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hvcc_parse #(
	parameter int COUNT_BITS = hvcc_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    in_byte,
	input  logic                          in_last,
	input  logic [hvcc_pkg::CAP_BITS-1:0] out_capacity,
	output hvcc_pkg::q_ctl_t              q_ctl,
	input  logic                          q_full,
	output hvcc_pkg::cmd_t                cmd
);
	import hvcc_pkg::*;

	localparam int SW = ((COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS) + 1;

	typedef enum logic [3:0] {
		PH_HDR, PH_ARR, PH_LEN, PH_PAY, PH_SKIP, PH_DONE, PH_ERR
	} phase_t;

	phase_t                phase_q, phase_n;
	logic [4:0]            hpos_q, hpos_n;
	logic [15:0]           first_q, first_n;
	logic [7:0]            arrays_q, arrays_n;
	logic [15:0]           nals_q, nals_n;
	logic [15:0]           payload_q, payload_n;
	logic [7:0]            hold_q, hold_n;
	logic [COUNT_BITS-1:0] count_q, count_n;
	logic [2:0]            lsz_q, lsz_n;
	logic [2:0]            err_q, err_n;

	logic                  accept;
	logic                  emit_start, emit_data;
	logic [2:0]            code;
	logic [15:0]           len;
	logic [15:0]           nals_dec;
	logic [SW-1:0]         need, cap, cnt_mask;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign len      = {hold_q, in_byte};
	assign nals_dec = nals_q - 16'd1;
	assign cnt_mask = SW'({COUNT_BITS{1'b1}});
	assign cap      = (SW'(out_capacity) > cnt_mask) ? cnt_mask : SW'(out_capacity);
	assign need     = SW'(count_q) + SW'(START_LEN) + SW'(len);

	always_comb begin
		phase_n    = phase_q;
		hpos_n     = hpos_q;
		first_n    = first_q;
		arrays_n   = arrays_q;
		nals_n     = nals_q;
		payload_n  = payload_q;
		hold_n     = hold_q;
		count_n    = count_q;
		lsz_n      = lsz_q;
		err_n      = err_q;
		emit_start = 1'b0;
		emit_data  = 1'b0;
		code       = ST_OK;
		if (accept) begin
			case (phase_q)
				PH_HDR: begin
					if (hpos_q < 5'd2) first_n = {first_q[7:0], in_byte};
					if (hpos_q == 5'd2 && first_q == 16'd0 && in_byte <= 8'd1) begin
						phase_n = PH_ERR;
						err_n   = ST_NOT_LP;
					end else begin
						if (hpos_q == 5'(HDR_LSZ_POS)) lsz_n = {1'b0, in_byte[1:0] & LSZ_MASK} + 3'd1;
						if (hpos_q == 5'(HDR_CNT_POS)) begin
							arrays_n = in_byte;
							phase_n  = (in_byte != 8'd0) ? PH_ARR : PH_DONE;
							hpos_n   = 5'd0;
						end else begin
							hpos_n = hpos_q + 5'd1;
						end
					end
				end
				PH_ARR: begin
					if (hpos_q == 5'd1) begin
						hold_n = in_byte;
						hpos_n = 5'd2;
					end else if (hpos_q == 5'd2) begin
						nals_n   = len;
						arrays_n = arrays_q - 8'd1;
						hpos_n   = 5'd0;
						if (len != 16'd0) phase_n = PH_LEN;
						else phase_n = (arrays_n != 8'd0) ? PH_ARR : PH_DONE;
					end else begin
						// array type byte is skipped
						hpos_n = 5'd1;
					end
				end
				PH_LEN: begin
					if (hpos_q == 5'd0) begin
						hold_n = in_byte;
						hpos_n = 5'd1;
					end else begin
						payload_n = len;
						if (need > cap) begin
							if (len == 16'd0) begin
								phase_n = PH_ERR;
								err_n   = ST_OVERFLOW;
							end else begin
								phase_n = PH_SKIP;
							end
						end else begin
							emit_start = 1'b1;
							count_n    = count_q + COUNT_BITS'(START_LEN);
							if (len != 16'd0) begin
								phase_n = PH_PAY;
							end else begin
								nals_n = nals_dec;
								hpos_n = 5'd0;
								if (nals_dec != 16'd0) phase_n = PH_LEN;
								else phase_n = (arrays_q != 8'd0) ? PH_ARR : PH_DONE;
							end
						end
					end
				end
				PH_PAY: begin
					emit_data = 1'b1;
					count_n   = count_q + COUNT_BITS'(1);
					payload_n = payload_q - 16'd1;
					if (payload_n == 16'd0) begin
						nals_n = nals_dec;
						hpos_n = 5'd0;
						if (nals_dec != 16'd0) phase_n = PH_LEN;
						else phase_n = (arrays_q != 8'd0) ? PH_ARR : PH_DONE;
					end
				end
				PH_SKIP: begin
					// payload of an overflowing nal is dropped
					payload_n = payload_q - 16'd1;
					if (payload_n == 16'd0) begin
						phase_n = PH_ERR;
						err_n   = ST_OVERFLOW;
					end
				end
				default: begin
				end
			endcase

			case (phase_n)
				PH_ERR:  code = err_n;
				PH_HDR:  code = (hpos_n <= 5'(SHORT_MAX)) ? ST_NOT_LP : ST_HDR_SHORT;
				PH_ARR:  code = ST_ARR_TRUNC;
				PH_LEN:  code = ST_LEN_TRUNC;
				PH_PAY:  code = ST_NAL_TRUNC;
				PH_SKIP: code = ST_NAL_TRUNC;
				default: code = ST_OK;
			endcase
		end
	end

	always_comb begin
		cmd.emit_start  = emit_start;
		cmd.emit_data   = emit_data;
		cmd.data        = in_byte;
		cmd.emit_status = in_last;
		cmd.code        = code;
		cmd.total       = (code == ST_OK) ? CAP_BITS'(count_n) : '0;
		cmd.lsz         = lsz_n;
		q_ctl.push      = accept && (emit_start || emit_data || in_last);
		q_ctl.full      = q_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HDR;
			hpos_q    <= '0;
			first_q   <= '0;
			arrays_q  <= '0;
			nals_q    <= '0;
			payload_q <= '0;
			hold_q    <= '0;
			count_q   <= '0;
			lsz_q     <= '0;
			err_q     <= '0;
		end else if (accept && in_last) begin
			// record done, start over
			phase_q   <= PH_HDR;
			hpos_q    <= '0;
			first_q   <= '0;
			arrays_q  <= '0;
			nals_q    <= '0;
			payload_q <= '0;
			hold_q    <= '0;
			count_q   <= '0;
			lsz_q     <= '0;
			err_q     <= '0;
		end else begin
			phase_q   <= phase_n;
			hpos_q    <= hpos_n;
			first_q   <= first_n;
			arrays_q  <= arrays_n;
			nals_q    <= nals_n;
			payload_q <= payload_n;
			hold_q    <= hold_n;
			count_q   <= count_n;
			lsz_q     <= lsz_n;
			err_q     <= err_n;
		end
	end

endmodule

[src/hvcc_queue.sv]
// ----------------------------------------------------------------------------
// hvcc_queue
// short command queue between the parser and the emitter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hvcc_to_annexb_converter_macros.svh"

module hvcc_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  hvcc_pkg::q_ctl_t q_ctl,
	input  hvcc_pkg::cmd_t   wr_cmd,
	input  logic             pop,
	output logic             full,
	output logic             empty,
	output hvcc_pkg::cmd_t   head
);
	import hvcc_pkg::*;

	cmd_t                 mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wptr_q, rptr_q;
	logic [QPTR_BITS:0]   count_q;

	assign full  = (count_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (q_ctl.push) mem_q[wptr_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (q_ctl.push) wptr_q <= wptr_q + 1'b1;
			if (pop) rptr_q <= rptr_q + 1'b1;
			if (q_ctl.push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !q_ctl.push) count_q <= count_q - 1'b1;
		end
	end

	`HVCC_ASSERT(a_no_push_full, clk, arst_n, !(q_ctl.push && full), "push into full queue")
	`HVCC_ASSERT(a_no_pop_empty, clk, arst_n, !(pop && empty), "pop from empty queue")
	`HVCC_ASSERT_NEXT(a_count_drop, clk, arst_n, pop && !q_ctl.push, count_q == $past(count_q) - 1'b1, "count did not drop on pop")
	`HVCC_ASSERT(a_count_range, clk, arst_n, count_q <= (QPTR_BITS+1)'(QUEUE_DEPTH), "queue count past depth")
	`HVCC_ASSERT(a_full_agree, clk, arst_n, q_ctl.full == full, "full flag seen by parser disagrees")

endmodule

[src/hvcc_emit.sv]
// ----------------------------------------------------------------------------
// hvcc_emit
// expands queued commands into start code, payload and status items
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hvcc_emit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          empty,
	input  hvcc_pkg::cmd_t                head,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    out_byte,
	output logic                          is_status,
	output logic [2:0]                    status,
	output logic [hvcc_pkg::CAP_BITS-1:0] total_bytes,
	output logic [2:0]                    length_field_size,
	output logic                          last
);
	import hvcc_pkg::*;

	logic [2:0] sub_q;
	logic [2:0] nbody, nitems;
	logic       take, last_item, body;

	assign nbody     = head.emit_start ? 3'(START_LEN) : (head.emit_data ? 3'd1 : 3'd0);
	assign nitems    = nbody + {2'b0, head.emit_status};
	assign take      = !empty && (!out_valid || out_ready);
	assign last_item = (sub_q + 3'd1 == nitems);
	assign body      = (sub_q < nbody);
	assign pop       = take && last_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			sub_q     <= '0;
		end else if (take) begin
			out_valid <= 1'b1;
			sub_q     <= last_item ? 3'd0 : sub_q + 3'd1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (body) begin
				// start code is 00 00 00 01
				if (head.emit_start) out_byte <= (sub_q == 3'(START_LEN - 1)) ? 8'd1 : 8'd0;
				else out_byte <= head.data;
				is_status         <= 1'b0;
				status            <= ST_OK;
				total_bytes       <= '0;
				length_field_size <= '0;
				last              <= 1'b0;
			end else begin
				out_byte          <= 8'd0;
				is_status         <= 1'b1;
				status            <= head.code;
				total_bytes       <= head.total;
				length_field_size <= head.lsz;
				last              <= 1'b1;
			end
		end
	end

endmodule

[verif/tb_hvcc_to_annexb_converter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hvcc_to_annexb_converter
// self-checking bench: hvcc records (well formed, cut short, annex b style and
// noise) go in under random handshake gaps; a parser model predicts every
// start code, payload byte and closing status item and checks them in order.
// ----------------------------------------------------------------------------

package annexb_check_pkg;
	import hvcc_pkg::*;

	typedef struct packed {
		logic [7:0]          data;
		logic                is_stat;
		logic [2:0]          code;
		logic [CAP_BITS-1:0] total;
		logic [2:0]          lsz;
		logic                fin;
	} annexb_item_t;

	typedef enum logic [2:0] {
		P_HEADER, P_ARRAY, P_LENGTH, P_PAYLOAD, P_SKIP, P_DONE, P_ERROR
	} parse_phase_e;

	class annexb_stream_model;
		annexb_item_t        awaited_items[$];
		int unsigned         mismatches;
		logic [CAP_BITS-1:0] capacity;
		parse_phase_e        phase;
		logic [4:0]          hdr_pos;
		logic [15:0]         lead_bytes;
		logic [7:0]          arrays_left;
		logic [15:0]         nals_left;
		logic [15:0]         payload_left;
		logic [7:0]          hi_byte;
		logic [CAP_BITS-1:0] out_count;
		logic [2:0]          lsz;
		logic [2:0]          err_code;

		function new();
			mismatches = 0;
			capacity = CAP_RESET;
			restart();
		endfunction

		function void restart();
			phase = P_HEADER;
			hdr_pos = '0;
			lead_bytes = '0;
			arrays_left = '0;
			nals_left = '0;
			payload_left = '0;
			hi_byte = '0;
			out_count = '0;
			lsz = '0;
			err_code = ST_OK;
		endfunction

		function int outstanding();
			return awaited_items.size();
		endfunction

		function void add_item(logic [7:0] d, logic st, logic [2:0] c,
				logic [CAP_BITS-1:0] tot, logic [2:0] l);
			annexb_item_t it;
			it = '{d, st, c, tot, l, st};
			awaited_items.push_back(it);
		endfunction

		function void fail(logic [2:0] c);
			phase = P_ERROR;
			err_code = c;
		endfunction

		function void next_array();
			phase = (arrays_left != 0) ? P_ARRAY : P_DONE;
			hdr_pos = '0;
		endfunction

		function void end_nal();
			nals_left = nals_left - 16'd1;
			if (nals_left != 0) begin
				phase = P_LENGTH;
				hdr_pos = '0;
			end else begin
				next_array();
			end
		endfunction

		function void take_record_byte(logic [7:0] b, logic lst);
			logic [15:0] len;
			int unsigned need;
			logic [2:0]  code;
			case (phase)
				P_HEADER: begin
					if (hdr_pos < 2)
						lead_bytes = {lead_bytes[7:0], b};
					if (hdr_pos == 2 && lead_bytes == 0 && b <= 1) begin
						fail(ST_NOT_LP);
					end else begin
						if (hdr_pos == HDR_LSZ_POS)
							lsz = {1'b0, b[1:0] & LSZ_MASK} + 3'd1;
						if (hdr_pos == HDR_CNT_POS) begin
							arrays_left = b;
							next_array();
						end else begin
							hdr_pos = hdr_pos + 5'd1;
						end
					end
				end
				P_ARRAY: begin
					if (hdr_pos == 1) begin
						hi_byte = b;
						hdr_pos = 5'd2;
					end else if (hdr_pos == 2) begin
						nals_left = {hi_byte, b};
						arrays_left = arrays_left - 8'd1;
						if (nals_left != 0) begin
							phase = P_LENGTH;
							hdr_pos = '0;
						end else begin
							next_array();
						end
					end else begin
						hdr_pos = 5'd1;
					end
				end
				P_LENGTH: begin
					if (hdr_pos == 0) begin
						hi_byte = b;
						hdr_pos = 5'd1;
					end else begin
						len = {hi_byte, b};
						payload_left = len;
						need = out_count + START_LEN + len;
						if (need > capacity) begin
							// no start code; payload is swallowed
							if (len == 0)
								fail(ST_OVERFLOW);
							else
								phase = P_SKIP;
						end else begin
							for (int k = 0; k < START_LEN; k++)
								add_item((k == START_LEN - 1) ? 8'h01 : 8'h00, 1'b0, ST_OK, '0, '0);
							out_count = out_count + CAP_BITS'(START_LEN);
							if (len != 0)
								phase = P_PAYLOAD;
							else
								end_nal();
						end
					end
				end
				P_PAYLOAD: begin
					add_item(b, 1'b0, ST_OK, '0, '0);
					out_count = out_count + 1'b1;
					payload_left = payload_left - 16'd1;
					if (payload_left == 0)
						end_nal();
				end
				P_SKIP: begin
					payload_left = payload_left - 16'd1;
					if (payload_left == 0)
						fail(ST_OVERFLOW);
				end
				default: ;
			endcase

			if (lst) begin
				case (phase)
					P_ERROR:            code = err_code;
					P_HEADER:           code = (hdr_pos <= SHORT_MAX) ? ST_NOT_LP : ST_HDR_SHORT;
					P_ARRAY:            code = ST_ARR_TRUNC;
					P_LENGTH:           code = ST_LEN_TRUNC;
					P_PAYLOAD, P_SKIP:  code = ST_NAL_TRUNC;
					default:            code = ST_OK;
				endcase
				add_item(8'h00, 1'b1, code, (code == ST_OK) ? out_count : '0, lsz);
				restart();
			end
		endfunction

		function string item_str(annexb_item_t x);
			return $sformatf("byte %02h is_status %0d status %0d total %0d lsz %0d last %0d",
				x.data, x.is_stat, x.code, x.total, x.lsz, x.fin);
		endfunction

		function void check_output_item(annexb_item_t got);
			annexb_item_t want;
			if (awaited_items.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output item: %s", item_str(got));
				return;
			end
			want = awaited_items.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected %s, got %s", item_str(want), item_str(got));
			end
		endfunction
	endclass
endpackage

module tb_hvcc_to_annexb_converter;
	import hvcc_pkg::*;
	import annexb_check_pkg::*;

	localparam int ITEM_TARGET    = 470;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 12;
	localparam int HOLD_CYCLES    = 120;
	localparam int NUM_PHASES     = 4;
	localparam logic [2:0] REG_OUT_CAPACITY = 3'd0;

	typedef enum int {
		K_WELL_FORMED, K_TRUNCATED, K_SHORT, K_ANNEXB, K_NOISE
	} rec_kind_e;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [2:0]          paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;
	logic                in_valid;
	logic                in_ready;
	logic [7:0]          in_byte;
	logic                in_last;
	logic                out_valid;
	logic                out_ready;
	logic [7:0]          out_byte;
	logic                is_status;
	logic [2:0]          status;
	logic [CAP_BITS-1:0] total_bytes;
	logic [2:0]          length_field_size;
	logic                last;

	annexb_stream_model model = new();
	logic [7:0] rec_bytes[$];
	int         items_sent = 0;
	int         quiet_cycles = 0;
	bit         hold_req = 1'b0;

	hvcc_to_annexb_converter dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.in_byte           (in_byte),
		.in_last           (in_last),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.out_byte          (out_byte),
		.is_status         (is_status),
		.status            (status),
		.total_bytes       (total_bytes),
		.length_field_size (length_field_size),
		.last              (last)
	);

	always #6 clk = ~clk;

	// both channels observed at the edge, input before output
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				model.take_record_byte(in_byte, in_last);
			if (out_valid && out_ready)
				model.check_output_item('{out_byte, is_status, status, total_bytes,
					length_field_size, last});
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("== FAIL ==");
		$finish;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(6, 25);
	endfunction

	function automatic int payload_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(25, 70);
		else
			return $urandom_range(0, 12);
	endfunction

	function automatic rec_kind_e pick_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return K_WELL_FORMED;
		else if (r < 70)
			return K_TRUNCATED;
		else if (r < 80)
			return K_SHORT;
		else if (r < 88)
			return K_ANNEXB;
		else
			return K_NOISE;
	endfunction

	// receiver: random stalls, long ready runs, and one long hold on request
	initial begin
		int stall;
		int run;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				stall = HOLD_CYCLES;
				hold_req = 1'b0;
			end else begin
				stall = idle_len();
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			run = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 24);
			repeat (run) begin
				@(posedge clk);
				if (hold_req)
					break;
			end
		end
	end

	task automatic write_capacity(input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_OUT_CAPACITY;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		model.capacity = value[CAP_BITS-1:0];
	endtask

	task automatic send_byte(input logic [7:0] b, input logic fin, input bit steady);
		int gap;
		gap = steady ? 0 : idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		in_last <= fin;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic send_record(input bit steady);
		for (int i = 0; i < rec_bytes.size(); i++)
			send_byte(rec_bytes[i], i == rec_bytes.size() - 1, steady);
	endtask

	task automatic wait_for_outputs();
		in_valid <= 1'b0;
		@(posedge clk);
		while (model.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic build_record(input rec_kind_e kind, input bit bulky);
		int  limit;
		int  n_arr;
		int  n_nal;
		int  len;
		bit  cut;
		rec_bytes.delete();
		cut = (kind == K_TRUNCATED);
		case (kind)
			K_SHORT: begin
				repeat ($urandom_range(1, HDR_LEN - 1)) rec_bytes.push_back(8'($urandom));
			end
			K_ANNEXB: begin
				rec_bytes.push_back(8'h00);
				rec_bytes.push_back(8'h00);
				rec_bytes.push_back(8'($urandom_range(0, 1)));
				repeat ($urandom_range(0, 30)) rec_bytes.push_back(8'($urandom));
			end
			K_NOISE: begin
				repeat ($urandom_range(1, 48)) rec_bytes.push_back(8'($urandom));
			end
			default: begin
				limit = cut ? HDR_LEN + $urandom_range(0, 50) : 32'h7fffffff;
				rec_bytes.push_back(8'($urandom_range(1, 255)));
				repeat (HDR_LSZ_POS - 1) rec_bytes.push_back(8'($urandom));
				rec_bytes.push_back(8'($urandom));
				if (bulky)
					n_arr = 1;
				else if (cut && $urandom_range(0, 7) == 0)
					n_arr = 255;
				else
					n_arr = $urandom_range(0, 3);
				rec_bytes.push_back(8'(n_arr));
				for (int a = 0; a < n_arr && rec_bytes.size() < limit; a++) begin
					rec_bytes.push_back(8'($urandom));
					if (bulky)
						n_nal = 2;
					else if (cut && $urandom_range(0, 5) == 0)
						n_nal = $urandom_range(0, 65535);
					else
						n_nal = $urandom_range(0, 3);
					rec_bytes.push_back(8'(n_nal >> 8));
					rec_bytes.push_back(8'(n_nal));
					for (int n = 0; n < n_nal && rec_bytes.size() < limit; n++) begin
						if (bulky)
							len = $urandom_range(30, 45);
						else if (cut && $urandom_range(0, 5) == 0)
							len = $urandom_range(0, 65535);
						else
							len = payload_len();
						rec_bytes.push_back(8'(len >> 8));
						rec_bytes.push_back(8'(len));
						for (int p = 0; p < len && rec_bytes.size() < limit; p++)
							rec_bytes.push_back(8'($urandom));
					end
				end
				// trailing bytes after the last array are ignored
				if (kind == K_WELL_FORMED && !bulky && $urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 4)) rec_bytes.push_back(8'($urandom));
				while (rec_bytes.size() > limit)
					void'(rec_bytes.pop_back());
			end
		endcase
	endtask

	initial begin
		logic [31:0] caps[NUM_PHASES];
		int          per_phase;
		int          phase_start;
		int          n_rec;

		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		in_byte = '0;
		in_last = 1'b0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// record of one byte, annex b start, ignored bytes after the error
		rec_bytes = '{8'hFF};
		send_record(1'b0);
		rec_bytes = '{8'h00, 8'h00, 8'h01};
		send_record(1'b0);
		rec_bytes = '{8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF};
		send_record(1'b1);
		// header too short
		rec_bytes = '{8'h00, 8'h00, 8'h02, 8'hFF};
		send_record(1'b0);
		rec_bytes = '{8'h00, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'h55};
		send_record(1'b0);

		// reset capacity, then the low extreme, a mid value and the high extreme
		caps[0] = CAP_RESET;
		caps[1] = 32'd0;
		caps[2] = $urandom_range(24, 160);
		caps[3] = CAP_RESET;
		per_phase = (ITEM_TARGET - items_sent) / NUM_PHASES;

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph > 0) begin
				wait_for_outputs();
				write_capacity(caps[ph]);
			end
			phase_start = items_sent;
			n_rec = 0;
			while (items_sent - phase_start < per_phase) begin
				if (ph == NUM_PHASES - 1 && n_rec == 0) begin
					// receiver holds off while a long record keeps coming
					hold_req = 1'b1;
					build_record(K_WELL_FORMED, 1'b1);
				end else if (ph == 0 && n_rec < 5) begin
					build_record(rec_kind_e'(n_rec), 1'b0);
				end else begin
					build_record(pick_kind(), 1'b0);
				end
				send_record($urandom_range(0, 3) == 0);
				n_rec++;
			end
		end

		wait_for_outputs();
		if (model.mismatches == 0 && model.outstanding() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
